// File: design/assert_macros.svh
// Assertion macros for the checker module of the swerve kinematics block.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is low
`define SWK_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is low
`define SWK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/swk_pkg.sv
// Types, constants and helper functions for the swerve wheel kinematics block.
// No dependencies; imported by the wheel, top, checker and testbench modules.
package swk_pkg;

	localparam int CORDIC_STEPS_DEF   = 16;
	localparam int ENCODER_COUNTS_DEF = 1024;
	localparam int SQRT_STEPS         = 17;
	localparam int ACC_BITS           = 20;
	localparam int CW                 = 30;
	localparam int CFG_IDX_W          = 1;

	localparam logic signed [31:0] SQRT2_Q14    = 32'sd23170;
	localparam logic signed [31:0] ROUND_Q14    = 32'sd8192;
	localparam logic [15:0]        QUARTER_TURN = 16'h4000;
	localparam logic [15:0]        HALF_TURN    = 16'h8000;
	localparam logic [11:0]        WINDOW_RST   = 12'd640;
	localparam logic [11:0]        OFFSET_RST   = 12'd773;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ALIGN_WINDOW,
		CFG_STEER_OFFSET
	} swk_cfg_idx_t;

	typedef struct packed {
		logic signed [15:0] cmd_x;
		logic signed [15:0] cmd_y;
		logic signed [15:0] cmd_rot;
		logic [9:0]         enc_front_right;
		logic [9:0]         enc_back_right;
		logic [9:0]         enc_back_left;
		logic [9:0]         enc_front_left;
	} swk_in_t;

	typedef struct packed {
		logic [15:0]        speed_front_right;
		logic [15:0]        speed_back_right;
		logic [15:0]        speed_back_left;
		logic [15:0]        speed_front_left;
		logic signed [15:0] steer_front_right;
		logic signed [15:0] steer_back_right;
		logic signed [15:0] steer_back_left;
		logic signed [15:0] steer_front_left;
		logic [3:0]         aligned_mask;
		logic [3:0]         invert_mask;
	} swk_out_t;

	// Per-wheel result handed from a wheel pipeline to the top level
	typedef struct packed {
		logic [15:0]        mag;
		logic signed [15:0] steer;
		logic               aligned;
		logic               inv;
	} swk_wheel_res_t;

	// Index of the last CORDIC / square-root stage in a wheel pipeline
	function automatic int swk_last_stage(input int cs);
		int a;
		int b;
		a = cs + 1;
		b = SQRT_STEPS + 2;
		return (a > b) ? a : b;
	endfunction

	// Whole latency of the block in cycles, output register included
	function automatic int swk_depth(input int cs);
		return swk_last_stage(cs) + 9;
	endfunction

	// Arctangent of 2^-i in 1/2^20 turn
	function automatic logic [ACC_BITS-1:0] swk_atan(input int i);
		logic [ACC_BITS-1:0] v;
		case (i)
			0:       v = 20'd131072;
			1:       v = 20'd77376;
			2:       v = 20'd40884;
			3:       v = 20'd20753;
			4:       v = 20'd10417;
			5:       v = 20'd5213;
			6:       v = 20'd2607;
			7:       v = 20'd1304;
			8:       v = 20'd652;
			9:       v = 20'd326;
			10:      v = 20'd163;
			11:      v = 20'd81;
			12:      v = 20'd41;
			13:      v = 20'd20;
			14:      v = 20'd10;
			15:      v = 20'd5;
			16:      v = 20'd3;
			17:      v = 20'd1;
			18:      v = 20'd1;
			default: v = 20'd0;
		endcase
		return v;
	endfunction

	// Wrap a 10-bit encoder count into one turn (at most four laps to remove)
	function automatic logic [9:0] swk_enc_wrap(input logic [9:0] e, input int ec);
		logic [16:0] v;
		logic [16:0] lim;
		v   = 17'(e);
		lim = 17'(ec);
		for (int i = 0; i < 4; i++) begin
			if (v >= lim) begin
				v = v - lim;
			end
		end
		return v[9:0];
	endfunction

endpackage

// File: design/swk_wheel.sv
// One wheel: pipelined CORDIC angle, digit-by-digit magnitude, encoder angle and steer error.
// Depends on swk_pkg.
module swk_wheel #(
	parameter int CORDIC_STEPS   = swk_pkg::CORDIC_STEPS_DEF,
	parameter int ENCODER_COUNTS = swk_pkg::ENCODER_COUNTS_DEF
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [17:0]     sx,
	input  logic signed [17:0]     sy,
	input  logic [9:0]             enc_cnt,
	input  logic [11:0]            align_window,
	input  logic [11:0]            steer_offset,
	output swk_pkg::swk_wheel_res_t res
);
	import swk_pkg::*;

	localparam int          T     = swk_last_stage(CORDIC_STEPS);
	localparam logic [16:0] EC    = 17'(ENCODER_COUNTS);
	localparam logic [24:0] RECIP = 25'((64'd1 << 32) / ENCODER_COUNTS);

	logic signed [CW-1:0] cx_s   [0:T];
	logic signed [CW-1:0] cy_s   [0:T];
	logic [ACC_BITS-1:0]  acc_s  [0:T];
	logic                 zero_s [0:T];
	logic [33:0]          rad_s  [1:T];
	logic [19:0]          rem_s  [1:T];
	logic [16:0]          root_s [1:T];
	logic [15:0]          enc_s  [2:T];

	logic [33:0] sqx_s0, sqy_s0;
	logic [34:0] encp_s0;
	logic [9:0]  m_s0;
	logic [15:0] q0_s1;
	logic [27:0] res_s1;

	logic signed [35:0]   sxe, sye;
	logic signed [35:0]   px, py;
	logic                 neg;
	logic signed [CW-1:0] vxe, vye;
	logic [34:0]          me;

	// Squares, half-turn pre-rotation and reciprocal product
	assign sxe = 36'(sx);
	assign sye = 36'(sy);
	assign px  = sxe * sxe;
	assign py  = sye * sye;
	assign neg = sx[17];
	assign vxe = neg ? -CW'(sx) : CW'(sx);
	assign vye = neg ? -CW'(sy) : CW'(sy);
	assign me  = 35'(enc_cnt);

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s0    <= px[33:0];
			sqy_s0    <= py[33:0];
			cx_s[0]   <= vxe <<< 8;
			cy_s[0]   <= vye <<< 8;
			acc_s[0]  <= {neg, {(ACC_BITS-1){1'b0}}};
			zero_s[0] <= (sx == 18'sd0) && (sy == 18'sd0);
			encp_s0   <= me * 35'(RECIP);
			m_s0      <= enc_cnt;
		end
	end

	for (genvar k = 1; k <= T; k++) begin : g_stage
		localparam int                  J  = k - 1;
		localparam int                  SJ = k - 2;
		localparam logic [ACC_BITS-1:0] AT = swk_atan(J);

		// CORDIC vectoring step J, or carry the vector on
		if (J < CORDIC_STEPS) begin : g_cordic
			logic signed [CW-1:0] dx, dy;
			assign dx = cy_s[k-1] >>> J;
			assign dy = cx_s[k-1] >>> J;
			always_ff @(posedge clk) begin
				if (en) begin
					if (cy_s[k-1] > 0) begin
						cx_s[k]  <= cx_s[k-1] + dx;
						cy_s[k]  <= cy_s[k-1] - dy;
						acc_s[k] <= acc_s[k-1] + AT;
					end else begin
						cx_s[k]  <= cx_s[k-1] - dx;
						cy_s[k]  <= cy_s[k-1] + dy;
						acc_s[k] <= acc_s[k-1] - AT;
					end
				end
			end
		end else begin : g_cpass
			always_ff @(posedge clk) begin
				if (en) begin
					cx_s[k]  <= cx_s[k-1];
					cy_s[k]  <= cy_s[k-1];
					acc_s[k] <= acc_s[k-1];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[k] <= zero_s[k-1];
			end
		end

		// Square root: load the sum of squares, then one result bit per stage
		if (k == 1) begin : g_sqload
			always_ff @(posedge clk) begin
				if (en) begin
					rad_s[k]  <= sqx_s0 + sqy_s0;
					rem_s[k]  <= '0;
					root_s[k] <= '0;
				end
			end
		end else if (SJ < SQRT_STEPS) begin : g_sqstep
			logic [21:0] rsh, trial;
			assign rsh   = {rem_s[k-1], rad_s[k-1][33:32]};
			assign trial = 22'({root_s[k-1], 2'b01});
			always_ff @(posedge clk) begin
				if (en) begin
					rad_s[k] <= rad_s[k-1] << 2;
					if (rsh >= trial) begin
						rem_s[k]  <= 20'(rsh - trial);
						root_s[k] <= {root_s[k-1][15:0], 1'b1};
					end else begin
						rem_s[k]  <= rsh[19:0];
						root_s[k] <= {root_s[k-1][15:0], 1'b0};
					end
				end
			end
		end else begin : g_sqpass
			always_ff @(posedge clk) begin
				if (en) begin
					rad_s[k]  <= rad_s[k-1];
					rem_s[k]  <= rem_s[k-1];
					root_s[k] <= root_s[k-1];
				end
			end
		end

		// Encoder angle: estimate quotient, then residual, then correct by one
		if (k == 1) begin : g_encq
			logic [15:0] q0;
			logic [33:0] qe;
			assign q0 = encp_s0[31:16];
			assign qe = 34'(q0) * 34'(EC);
			always_ff @(posedge clk) begin
				if (en) begin
					q0_s1  <= q0;
					res_s1 <= 28'({m_s0, 16'h0000}) - qe[27:0];
				end
			end
		end else if (k == 2) begin : g_encfix
			logic [15:0] q;
			assign q = q0_s1 + 16'((res_s1 >= 28'(EC)) ? 1 : 0);
			always_ff @(posedge clk) begin
				if (en) begin
					enc_s[k] <= q + QUARTER_TURN;
				end
			end
		end else begin : g_encpass
			always_ff @(posedge clk) begin
				if (en) begin
					enc_s[k] <= enc_s[k-1];
				end
			end
		end
	end

	logic [15:0]        ang_f1, ang_f2, enc_f1, enc_f2;
	logic [17:0]        mag_f1;
	logic [15:0]        mag_f2, mag_f3, mag_f4;
	logic               inv_f2, inv_f3, inv_f4;
	logic signed [17:0] err_f3;
	logic signed [15:0] steer_f4;
	logic               aligned_f4;

	logic [20:0]        acc_rnd;
	logic               rnd_up;
	logic signed [17:0] win, off, err_sh, steer_n;

	assign acc_rnd = {1'b0, acc_s[T]} + 21'd8;
	assign rnd_up  = rem_s[T] > 20'(root_s[T]);

	// Round the angle to 1/65536 turn and the magnitude to nearest
	always_ff @(posedge clk) begin
		if (en) begin
			ang_f1 <= zero_s[T] ? 16'h0000 : acc_rnd[19:4];
			mag_f1 <= 18'(root_s[T]) + 18'(rnd_up);
			enc_f1 <= enc_s[T];
		end
	end

	// Fold angles past a half turn and saturate the magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			if (ang_f1 > HALF_TURN) begin
				ang_f2 <= ang_f1 - HALF_TURN;
				inv_f2 <= 1'b1;
			end else begin
				ang_f2 <= ang_f1;
				inv_f2 <= 1'b0;
			end
			mag_f2 <= (mag_f1 > 18'd65535) ? 16'hFFFF : mag_f1[15:0];
			enc_f2 <= enc_f1;
		end
	end

	// Steering error against the encoder angle
	always_ff @(posedge clk) begin
		if (en) begin
			err_f3 <= $signed({2'b00, ang_f2}) - $signed({2'b00, enc_f2});
			mag_f3 <= mag_f2;
			inv_f3 <= inv_f2;
		end
	end

	// Window check and steer command pushed out by the offset
	assign win     = $signed({6'b000000, align_window});
	assign off     = $signed({6'b000000, steer_offset});
	assign err_sh  = err_f3 >>> 2;
	assign steer_n = (err_f3 > 18'sd0) ? (err_sh + off) : (err_sh - off);

	always_ff @(posedge clk) begin
		if (en) begin
			aligned_f4 <= (err_f3 < win) && (err_f3 > -win);
			steer_f4   <= steer_n[15:0];
			mag_f4     <= mag_f3;
			inv_f4     <= inv_f3;
		end
	end

	assign res.mag     = mag_f4;
	assign res.steer   = steer_f4;
	assign res.aligned = aligned_f4;
	assign res.inv     = inv_f4;

endmodule

// File: design/swerve_wheel_kinematics.sv
// Top level of the four-wheel swerve inverse kinematics block.
// Depends on swk_pkg and swk_wheel.
//
// Takes one drive command and four encoder counts per beat and returns, per wheel, speed,
// steer command, aligned and invert bits. The block accepts a new command in every cycle
// unless the result side is stalled. It is built from three stages of command arithmetic,
// a wheel core of max(CORDIC_STEPS + 2, 20) stages set by the longer of the CORDIC vectoring
// chain (pre-rotation, then one step per stage) and the digit-by-digit square root (squares,
// load and 17 digit stages), four of angle and error finishing, and the output register. The
// whole pipeline holds while a finished result waits to be taken. Registers align_window and
// steer_offset are written through cfg_we/cfg_index/cfg_data; the user must write them only
// while no command is in flight, as the block itself does not enforce it.
module swerve_wheel_kinematics #(
	parameter int CORDIC_STEPS   = swk_pkg::CORDIC_STEPS_DEF,
	parameter int ENCODER_COUNTS = swk_pkg::ENCODER_COUNTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  swk_pkg::swk_in_t              cmd,
	output logic                          res_valid,
	input  logic                          res_ready,
	output swk_pkg::swk_out_t             res,
	input  logic                          cfg_we,
	input  logic [swk_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [11:0]                   cfg_data
);
	import swk_pkg::*;

	localparam int DEPTH = swk_depth(CORDIC_STEPS);

	logic [DEPTH-1:0] vld_s;
	logic             advance;
	logic [11:0]      align_window_q, steer_offset_q;

	// Advance the whole pipeline unless the output beat is stuck
	assign advance   = !res_valid || res_ready;
	assign cmd_ready = advance;
	assign res_valid = vld_s[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (advance) begin
			vld_s <= {vld_s[DEPTH-2:0], cmd_valid};
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			align_window_q <= WINDOW_RST;
			steer_offset_q <= OFFSET_RST;
		end else if (cfg_we) begin
			case (swk_cfg_idx_t'(cfg_index))
				CFG_ALIGN_WINDOW: align_window_q <= cfg_data;
				CFG_STEER_OFFSET: steer_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic signed [31:0] rot_e;
	logic signed [31:0] rot_prod_s1;
	logic signed [15:0] x_s1, y_s1, x_s2, y_s2;
	logic [9:0]         m_s1 [4];
	logic [9:0]         m_s2 [4];
	logic [9:0]         m_s3 [4];
	logic signed [16:0] a_s2;
	logic signed [17:0] sx_s3 [4];
	logic signed [17:0] sy_s3 [4];
	logic signed [31:0] a_rnd;
	logic signed [17:0] xp, xm, yp, ym;

	assign rot_e = 32'(cmd.cmd_rot);

	// Stage 1: scale rotation by sqrt2, wrap encoder counts
	always_ff @(posedge clk) begin
		if (advance) begin
			rot_prod_s1 <= rot_e * SQRT2_Q14;
			x_s1        <= cmd.cmd_x;
			y_s1        <= cmd.cmd_y;
			m_s1[0]     <= swk_enc_wrap(cmd.enc_front_right, ENCODER_COUNTS);
			m_s1[1]     <= swk_enc_wrap(cmd.enc_back_right, ENCODER_COUNTS);
			m_s1[2]     <= swk_enc_wrap(cmd.enc_back_left, ENCODER_COUNTS);
			m_s1[3]     <= swk_enc_wrap(cmd.enc_front_left, ENCODER_COUNTS);
		end
	end

	// Stage 2: round the rotation term and drop its Q14 fraction
	assign a_rnd = (rot_prod_s1 + ROUND_Q14) >>> 14;

	always_ff @(posedge clk) begin
		if (advance) begin
			a_s2 <= a_rnd[16:0];
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			m_s2 <= m_s1;
		end
	end

	// Stage 3: form the four wheel vectors
	assign xp = 18'(x_s2) + 18'(a_s2);
	assign xm = 18'(x_s2) - 18'(a_s2);
	assign yp = 18'(y_s2) + 18'(a_s2);
	assign ym = 18'(y_s2) - 18'(a_s2);

	always_ff @(posedge clk) begin
		if (advance) begin
			sx_s3[0] <= xp;
			sy_s3[0] <= yp;
			sx_s3[1] <= xm;
			sy_s3[1] <= yp;
			sx_s3[2] <= xm;
			sy_s3[2] <= ym;
			sx_s3[3] <= xp;
			sy_s3[3] <= ym;
			m_s3     <= m_s2;
		end
	end

	swk_wheel_res_t wr [4];

	for (genvar w = 0; w < 4; w++) begin : g_wheel
		swk_wheel #(
			.CORDIC_STEPS  (CORDIC_STEPS),
			.ENCODER_COUNTS(ENCODER_COUNTS)
		) u_wheel (
			.clk         (clk),
			.en          (advance),
			.sx          (sx_s3[w]),
			.sy          (sy_s3[w]),
			.enc_cnt     (m_s3[w]),
			.align_window(align_window_q),
			.steer_offset(steer_offset_q),
			.res         (wr[w])
		);
	end

	logic [3:0] aligned_all;
	logic       all_on;

	assign aligned_all = {wr[3].aligned, wr[2].aligned, wr[1].aligned, wr[0].aligned};
	assign all_on      = &aligned_all;

	// Output register: drop the speeds unless every wheel is on target
	always_ff @(posedge clk) begin
		if (advance) begin
			res.speed_front_right <= all_on ? wr[0].mag : 16'h0000;
			res.speed_back_right  <= all_on ? wr[1].mag : 16'h0000;
			res.speed_back_left   <= all_on ? wr[2].mag : 16'h0000;
			res.speed_front_left  <= all_on ? wr[3].mag : 16'h0000;
			res.steer_front_right <= wr[0].steer;
			res.steer_back_right  <= wr[1].steer;
			res.steer_back_left   <= wr[2].steer;
			res.steer_front_left  <= wr[3].steer;
			res.aligned_mask      <= aligned_all;
			res.invert_mask       <= {wr[3].inv, wr[2].inv, wr[1].inv, wr[0].inv};
		end
	end

endmodule

// File: design/swk_checker.sv
// Port-level checks for swerve_wheel_kinematics, attached by the bind at the end.
// Depends on swk_pkg and assert_macros.svh.
`include "assert_macros.svh"

module swk_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cmd_valid,
	input logic                          cmd_ready,
	input swk_pkg::swk_in_t              cmd,
	input logic                          res_valid,
	input logic                          res_ready,
	input swk_pkg::swk_out_t             res,
	input logic                          cfg_we,
	input logic [swk_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [11:0]                   cfg_data
);
	import swk_pkg::*;

	// A stalled result beat holds
	`SWK_ASSERT(a_res_hold, clk, arst_n, res_valid && !res_ready |=> res_valid && $stable(res), "result beat changed while stalled")

	// Input side stalls only behind a stuck result
	`SWK_ASSERT(a_ready, clk, arst_n, cmd_ready == (!res_valid || res_ready), "cmd_ready out of step with output")

	// Speeds stay zero unless all four wheels are aligned
	`SWK_ASSERT(a_speed_gate, clk, arst_n, res_valid && res.aligned_mask != 4'hF |-> res.speed_front_right == 16'h0 && res.speed_back_right == 16'h0 && res.speed_back_left == 16'h0 && res.speed_front_left == 16'h0, "speed given to misaligned wheels")

	// No result beat once reset has been seen low at an edge
	`SWK_ASSERT_ALWAYS(a_rst, clk, !arst_n |=> !res_valid, "result valid during reset")

endmodule

bind swerve_wheel_kinematics swk_checker u_swk_checker (.*);

// File: dv/swerve_wheel_kinematics_tb.sv
// Self-checking testbench for the swerve wheel kinematics block.
// Depends on swk_pkg and the block's RTL; predicts each result and compares it in order.
module swerve_wheel_kinematics_tb;
	import swk_pkg::*;

	localparam int LATENCY   = swk_depth(CORDIC_STEPS_DEF);
	localparam int WDOG_MAX  = 20000;
	localparam int N_RANDOM  = 700;

	// Atan of 2^-i in 1/2^20 turn
	localparam longint ATAN_TURN [24] = '{131072, 77376, 40884, 20753, 10417, 5213, 2607,
		1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0, 0, 0, 0, 0};

	// Predicts wheel results and holds those still to arrive
	class wheel_scoreboard;
		swk_out_t pending[$];
		logic [11:0] window;
		logic [11:0] offset;
		int errors;

		function new();
			window = WINDOW_RST;
			offset = OFFSET_RST;
			errors = 0;
		endfunction

		static function longint floor_shr(longint v, int s);
			if (v >= 0) return v >>> s;
			return -1 - ((-1 - v) >>> s);
		endfunction

		static function longint wheel_mag(longint vx, longint vy);
			longint s, q, b, rem;
			s = vx * vx + vy * vy;
			q = 0;
			b = longint'(1) << 62;
			rem = s;
			while (b > s) b = b >> 2;
			while (b != 0) begin
				if (rem >= q + b) begin
					rem = rem - (q + b);
					q = (q >> 1) + b;
				end else begin
					q = q >> 1;
				end
				b = b >> 2;
			end
			if (s - q * q > q) q++;
			return (q > 65535) ? 65535 : q;
		endfunction

		static function longint wheel_angle(longint vx, longint vy);
			longint acc, x, y, dx, dy;
			acc = 0;
			if (vx == 0 && vy == 0) return 0;
			if (vx < 0) begin
				vx = -vx;
				vy = -vy;
				acc = longint'(1) << (ACC_BITS - 1);
			end
			x = vx * 256;
			y = vy * 256;
			for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
				dx = floor_shr(y, i);
				dy = floor_shr(x, i);
				if (y > 0) begin
					x += dx; y -= dy; acc += ATAN_TURN[i];
				end else begin
					x -= dx; y += dy; acc -= ATAN_TURN[i];
				end
			end
			acc = acc & ((longint'(1) << ACC_BITS) - 1);
			return ((acc + 8) >> 4) & 16'hFFFF;
		endfunction

		// Work out the expected result of one accepted command
		function void note_command(swk_in_t c);
			longint x, y, a, ang, enc_ang, err, st;
			longint sx[4], sy[4], mag[4];
			logic [9:0] enc[4];
			swk_out_t r;
			logic [3:0] al, inv;
			logic [15:0] steer[4];
			x = c.cmd_x; y = c.cmd_y;
			a = floor_shr(longint'(c.cmd_rot) * 23170 + 8192, 14);
			sx[0] = x + a; sy[0] = y + a;
			sx[1] = x - a; sy[1] = y + a;
			sx[2] = x - a; sy[2] = y - a;
			sx[3] = x + a; sy[3] = y - a;
			enc[0] = c.enc_front_right; enc[1] = c.enc_back_right;
			enc[2] = c.enc_back_left;   enc[3] = c.enc_front_left;
			al = 0; inv = 0;
			for (int w = 0; w < 4; w++) begin
				enc_ang = ((longint'(enc[w]) * 65536 / ENCODER_COUNTS_DEF) + 16384) & 16'hFFFF;
				ang = wheel_angle(sx[w], sy[w]);
				mag[w] = wheel_mag(sx[w], sy[w]);
				if (ang > 32768) begin
					ang -= 32768;
					inv[w] = 1'b1;
				end
				err = ang - enc_ang;
				if (err < longint'(window) && err > -longint'(window)) al[w] = 1'b1;
				st = floor_shr(err, 2);
				st = (err > 0) ? st + longint'(offset) : st - longint'(offset);
				steer[w] = st[15:0];
			end
			r.speed_front_right = (al == 4'hF) ? mag[0][15:0] : 16'd0;
			r.speed_back_right  = (al == 4'hF) ? mag[1][15:0] : 16'd0;
			r.speed_back_left   = (al == 4'hF) ? mag[2][15:0] : 16'd0;
			r.speed_front_left  = (al == 4'hF) ? mag[3][15:0] : 16'd0;
			r.steer_front_right = steer[0];
			r.steer_back_right  = steer[1];
			r.steer_back_left   = steer[2];
			r.steer_front_left  = steer[3];
			r.aligned_mask = al;
			r.invert_mask  = inv;
			pending.push_back(r);
		endfunction

		// Compare one result with the oldest expectation
		function void check_result(swk_out_t got);
			swk_out_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got !== e) begin
				$display("%0t: result mismatch, expected %h, actual %h", $time, e, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	swk_in_t cmd = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	swk_out_t res;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [11:0] cfg_data = '0;

	wheel_scoreboard sb = new();
	bit calm = 1'b0;
	int idle_cycles = 0;

	swerve_wheel_kinematics u_top (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Check results and count cycles with no beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && res_ready) sb.check_result(res);
			if ((res_valid && res_ready) || (cmd_valid && cmd_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= WDOG_MAX) begin
				$display("** swerve_wheel_kinematics: FAILED **");
				$finish;
			end
		end
	end

	// Stall the result side at random, except in calm stretches
	always @(negedge clk) begin
		res_ready <= calm ? 1'b1 : ($urandom_range(99) >= 22);
	end

	// Idle at random unless calm, hold the beat until taken; valid drops only while idling
	task automatic send_command(swk_in_t c);
		if (!calm) begin
			while ($urandom_range(99) < 22) begin
				cmd_valid <= 1'b0;
				@(negedge clk);
			end
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		sb.note_command(c);
		@(negedge clk);
	endtask

	task automatic write_reg(swk_cfg_idx_t idx, logic [11:0] v);
		cmd_valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_ALIGN_WINDOW) sb.window = v;
		else sb.offset = v;
	endtask

	function automatic logic signed [15:0] rand_cmd();
		case ($urandom_range(9))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'sd0;
			3: return 16'($urandom);
			default: return 16'($signed($urandom_range(32768)) - 16384);
		endcase
	endfunction

	function automatic swk_in_t rand_item();
		swk_in_t c;
		c.cmd_x = rand_cmd();
		c.cmd_y = rand_cmd();
		c.cmd_rot = ($urandom_range(3) == 0) ? 16'sd0 : rand_cmd();
		c.enc_front_right = 10'($urandom);
		c.enc_back_right  = 10'($urandom);
		c.enc_back_left   = 10'($urandom);
		c.enc_front_left  = 10'($urandom);
		return c;
	endfunction

	// Build a command whose wheels sit near their own encoder reading
	function automatic swk_in_t aligned_item();
		swk_in_t c;
		longint ang, e;
		c = rand_item();
		c.cmd_rot = 16'sd0;
		ang = wheel_scoreboard::wheel_angle(c.cmd_x, c.cmd_y);
		if (ang > 32768) ang -= 32768;
		e = (((ang - 16384) & 16'hFFFF) * 1024) >> 16;
		e = e + $signed($urandom_range(2)) - 1;
		c.enc_front_right = 10'(e);
		c.enc_back_right  = 10'(e);
		c.enc_back_left   = 10'(e);
		c.enc_front_left  = 10'(e);
		return c;
	endfunction

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) begin
			calm = (i >= n / 3) && (i < n / 3 + 40);
			send_command(($urandom_range(1)) ? aligned_item() : rand_item());
		end
		calm = 1'b0;
	endtask

	initial begin
		swk_in_t c;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: extremes, zero vector, axis vectors, pure rotation, half turn, zero error
		c = '0;                         send_command(c);
		c.cmd_x = 16'sd16384;           send_command(c);
		c = '0; c.cmd_x = -16'sd16384;  send_command(c);
		c = '0; c.cmd_y = 16'sd16384;   send_command(c);
		c = '0; c.cmd_y = -16'sd16384;  send_command(c);
		c = '0; c.cmd_rot = 16'sd16384; send_command(c);
		c = '0; c.cmd_rot = -16'sd16384; send_command(c);
		c = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF};
		send_command(c);
		c = '{16'sh8000, 16'sh8000, 16'sh8000, 10'h000, 10'h200, 10'h155, 10'h2AA};
		send_command(c);
		c = '0; c.cmd_y = 16'sd100;
		c.enc_front_right = 10'd0; c.enc_back_right = 10'd0;
		c.enc_back_left = 10'd0; c.enc_front_left = 10'd0;
		send_command(c);
		c = '0; c.cmd_x = 16'sd5000;
		c.enc_front_right = 10'd768; c.enc_back_right = 10'd768;
		c.enc_back_left = 10'd768; c.enc_front_left = 10'd768;
		send_command(c);
		for (int i = 0; i < 8; i++) send_command(aligned_item());

		random_phase(N_RANDOM / 4);
		write_reg(CFG_ALIGN_WINDOW, 12'd0);
		write_reg(CFG_STEER_OFFSET, 12'd0);
		random_phase(N_RANDOM / 4);
		write_reg(CFG_ALIGN_WINDOW, 12'hFFF);
		write_reg(CFG_STEER_OFFSET, 12'hFFF);
		random_phase(N_RANDOM / 4);
		write_reg(CFG_ALIGN_WINDOW, 12'($urandom));
		write_reg(CFG_STEER_OFFSET, 12'($urandom));
		random_phase(N_RANDOM / 4);

		// Drop valid, drain, then let the pipeline settle
		cmd_valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
		if (sb.errors == 0) begin
			$display("** swerve_wheel_kinematics: PASSED **");
		end else begin
			$display("** swerve_wheel_kinematics: FAILED **");
		end
		$finish;
	end

endmodule

// File: swerve_wheel_kinematics.f
+incdir+design
design/swk_pkg.sv
design/swk_wheel.sv
design/swerve_wheel_kinematics.sv
design/swk_checker.sv
dv/swerve_wheel_kinematics_tb.sv
